// File: design/lgrs_pkg.sv
// Shared constants and control types for the Life row-stream generator.
package lgrs_pkg;

  // Fixed field widths on the stream and configuration ports
  localparam int ROW_W = 64;
  localparam int CFG_W = 7;

  // Default cell count and reset width
  localparam int MAX_WIDTH_DEF = 64;
  localparam logic [CFG_W-1:0] GRID_WIDTH_RST = 7'd64;

  // Neighbor counts for the B3/S23 rule
  localparam logic [3:0] BIRTH_CNT = 4'd3;
  localparam logic [3:0] KEEP_CNT = 4'd2;

  // Control from the sequencer to the cell chain and output register
  typedef struct packed {
    logic step;        // input transfer: shift rows up by one
    logic zero_above;  // first row of a frame: dead row above
    logic flush;       // bottom-row result: dead row below
    logic load_out;    // capture a result into the output register
    logic out_last;    // captured result closes the frame
  } lgrs_ctl_t;

endpackage

// File: design/life_generation_row_stream.sv
// Top level: Conway Life (B3/S23) generation over a grid streamed row by row.
//
//  channel   | dir | handshake                    | content
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | current row, bottom-row mark
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | next-generation row, frame end
//  cfg       | in  | cfg_valid/cfg_ready          | grid_width
//
// One row per cycle unless stalled: each column cell evaluates its neighbors combinationally.
// Results trail the input by one row; the bottom row needs an extra flush step for
// its result, during which s_axis_tready is low.
// Reset (rst, synchronous) drops any held rows and sets grid_width to 64.
// A stalled output register blocks input only when it is full and not taken.
module life_generation_row_stream #(
  parameter int MAX_WIDTH = lgrs_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [lgrs_pkg::ROW_W-1:0] s_axis_tdata,   // [63:0] row_cells
  input  logic                      s_axis_tlast,   // final_row
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [lgrs_pkg::ROW_W-1:0] m_axis_tdata,   // [63:0] next_row
  output logic                      m_axis_tlast,   // frame_done
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lgrs_pkg::CFG_W-1:0] cfg_data        // [6:0] grid_width
);
  import lgrs_pkg::*;

  localparam logic [CFG_W-1:0] MAX_W = CFG_W'(MAX_WIDTH);

  logic [CFG_W-1:0]     grid_width;
  logic [CFG_W-1:0]     eff_width;
  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH-1:0] below_v;
  logic [MAX_WIDTH-1:0] above_v;
  logic [MAX_WIDTH-1:0] mid_v;
  logic [MAX_WIDTH-1:0] next_v;
  logic [MAX_WIDTH+1:0] above_pad;
  logic [MAX_WIDTH+1:0] mid_pad;
  logic [MAX_WIDTH+1:0] below_pad;
  logic [MAX_WIDTH-1:0] out_row;
  logic                 out_last;
  lgrs_ctl_t            ctl;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GRID_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      grid_width <= cfg_data;
    end
  end

  // Column mask from the clamped width
  assign eff_width = (grid_width > MAX_W) ? MAX_W : grid_width;
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = (CFG_W'(i) < eff_width);
    end
  end

  // Row below: new row, or dead row during the flush
  assign below_v   = ctl.flush ? '0 : (s_axis_tdata[MAX_WIDTH-1:0] & mask);
  assign above_pad = {1'b0, above_v, 1'b0};
  assign mid_pad   = {1'b0, mid_v, 1'b0};
  assign below_pad = {1'b0, below_v, 1'b0};

  lgrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .ctl       (ctl)
  );

  // Chain of column cells, each wired to its left and right neighbor
  for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_col
    lgrs_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .en          (mask[g]),
      .below       (below_v[g]),
      .left_above  (above_pad[g]),
      .left_mid    (mid_pad[g]),
      .left_below  (below_pad[g]),
      .right_above (above_pad[g+2]),
      .right_mid   (mid_pad[g+2]),
      .right_below (below_pad[g+2]),
      .above_out   (above_v[g]),
      .mid_out     (mid_v[g]),
      .next_bit    (next_v[g])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_row  <= next_v;
      out_last <= ctl.out_last;
    end
  end

  assign m_axis_tdata = ROW_W'(out_row);
  assign m_axis_tlast = out_last;

endmodule

// File: design/lgrs_cell.sv
// One column cell: holds the column's above and middle bits, applies B3/S23.
module lgrs_cell (
  input  logic              clk,
  input  lgrs_pkg::lgrs_ctl_t ctl,
  input  logic              en,          // column lies inside the grid width
  input  logic              below,       // new row bit, already masked
  input  logic              left_above,
  input  logic              left_mid,
  input  logic              left_below,
  input  logic              right_above,
  input  logic              right_mid,
  input  logic              right_below,
  output logic              above_out,   // masked bits handed to neighbors
  output logic              mid_out,
  output logic              next_bit
);
  import lgrs_pkg::*;

  logic       above;
  logic       middle;
  logic [3:0] nbr_cnt;

  assign above_out = above & en;
  assign mid_out   = middle & en;

  // Eight-neighbor count and rule
  always_comb begin
    nbr_cnt = 4'(left_above) + 4'(above_out) + 4'(right_above)
            + 4'(left_mid) + 4'(right_mid)
            + 4'(left_below) + 4'(below) + 4'(right_below);
    next_bit = en & ((nbr_cnt == BIRTH_CNT) | (mid_out & (nbr_cnt == KEEP_CNT)));
  end

  // Row shift on each input transfer
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      above  <= ctl.zero_above ? 1'b0 : middle;
      middle <= below;
    end
  end

endmodule

// File: design/lgrs_ctrl.sv
// Sequencer: held-row and flush tracking plus output handshake.
module lgrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output lgrs_pkg::lgrs_ctl_t ctl
);
  import lgrs_pkg::*;

  logic middle_valid;
  logic flush_pend;
  logic out_free;
  logic acc;
  logic fire_flush;

  // Handshake decode
  always_comb begin
    out_free   = !out_valid || out_ready;
    in_ready   = !flush_pend && out_free;
    acc        = in_valid && in_ready;
    fire_flush = flush_pend && out_free;

    ctl.step       = acc;
    ctl.zero_above = !middle_valid;
    ctl.flush      = flush_pend;
    ctl.load_out   = (acc && middle_valid) || fire_flush;
    ctl.out_last   = fire_flush;
  end

  // Frame state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      middle_valid <= 1'b0;
      flush_pend   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (fire_flush) begin
        middle_valid <= 1'b0;
        flush_pend   <= 1'b0;
      end else if (acc) begin
        middle_valid <= 1'b1;
        flush_pend   <= in_last;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/lgrs_chk.sv
// Port-level checker for the Life row-stream generator, bound to the top level.
module lgrs_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tlast,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [lgrs_pkg::ROW_W-1:0] m_axis_tdata,
  input logic                       m_axis_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Input is blocked in the cycle after a bottom-row transfer, while its flush result is due
  a_flush_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted during flush");

  // Full, stalled output register blocks input
  a_out_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted with result stalled");

  // No result straight out of reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind life_generation_row_stream lgrs_chk u_lgrs_chk (.*);

// File: bench/testbench.sv
// Self-checking bench for the Life row-stream generator: random stalls, width sweeps, backpressure.
`timescale 1ns / 100ps

module testbench;
  import lgrs_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int HOLD_CYCLES = 200;    // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;    // quiet time before a register write
  localparam int STALL_LIMIT = 3000;   // cycles with no transfer before giving up
  localparam int RANDOM_ROWS = 620;

  typedef struct {
    logic [ROW_W-1:0] cells;
    logic             frame_end;
  } gen_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ROW_W-1:0] s_axis_tdata = '0;     // [63:0] row_cells
  logic             s_axis_tlast = 1'b0;   // final_row
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ROW_W-1:0] m_axis_tdata;          // [63:0] next_row
  logic             m_axis_tlast;          // frame_done
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = GRID_WIDTH_RST;

  // Predictor state
  logic [CFG_W-1:0] grid_width = GRID_WIDTH_RST;
  logic [ROW_W-1:0] row_above = '0;
  logic [ROW_W-1:0] row_mid = '0;
  logic             middle_held = 1'b0;
  gen_row_t         expected_rows[$];

  int mismatches = 0;
  int rows_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;          // no gaps on either side
  int hold_requests = 0;      // bumped by tests, served by the receiver
  int hold_served = 0;
  int hold_left = 0;
  int sink_gap = 0;

  always #1 clk = ~clk;

  life_generation_row_stream #(.MAX_WIDTH(MAX_W)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Columns in use under the current width, clamped at the cell count
  function automatic logic [ROW_W-1:0] live_mask();
    int w;
    w = (int'(grid_width) > MAX_W) ? MAX_W : int'(grid_width);
    if (w >= ROW_W) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // One B3/S23 step of the middle row; dead cells beyond both edges
  function automatic logic [ROW_W-1:0] next_gen_row(logic [ROW_W-1:0] up,
                                                    logic [ROW_W-1:0] mid,
                                                    logic [ROW_W-1:0] down);
    logic [ROW_W-1:0] m, res;
    logic [ROW_W+1:0] u, c, d;
    int n;
    m = live_mask();
    u = {1'b0, up & m, 1'b0};
    c = {1'b0, mid & m, 1'b0};
    d = {1'b0, down & m, 1'b0};
    res = '0;
    for (int col = 0; col < ROW_W; col++) begin
      n = $countones({u[col+2 -: 3], c[col], c[col+2], d[col+2 -: 3]});
      if (c[col+1])
        res[col] = (n == int'(KEEP_CNT)) || (n == int'(BIRTH_CNT));
      else
        res[col] = (n == int'(BIRTH_CNT));
    end
    return res & m;
  endfunction

  // Row window update for one accepted row; queues the rows it produces
  function automatic void track_row(logic [ROW_W-1:0] cells, logic bottom);
    logic [ROW_W-1:0] row;
    row = cells & live_mask();
    if (middle_held) begin
      expected_rows.push_back('{next_gen_row(row_above, row_mid, row), 1'b0});
      row_above = row_mid;
      row_mid = row;
    end else begin
      row_above = '0;
      row_mid = row;
      middle_held = 1'b1;
    end
    if (bottom) begin
      expected_rows.push_back('{next_gen_row(row_above, row_mid, '0), 1'b1});
      row_above = '0;
      row_mid = '0;
      middle_held = 1'b0;
    end
  endfunction

  function automatic void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_row(logic [ROW_W-1:0] cells, logic frame_end);
    gen_row_t want;
    if (expected_rows.size() == 0) begin
      report($sformatf("unexpected row %h last %b", cells, frame_end));
      return;
    end
    want = expected_rows.pop_front();
    if (cells !== want.cells)
      report($sformatf("next_row exp %h got %h", want.cells, cells));
    if (frame_end !== want.frame_end)
      report($sformatf("frame_done exp %b got %b", want.frame_end, frame_end));
  endfunction

  // Monitor: check results first, then predict from accepted rows and writes
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_row(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) track_row(s_axis_tdata, s_axis_tlast);
      if (cfg_valid && cfg_ready) grid_width = cfg_data;
    end
  end

  // Receiver pacing: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      m_axis_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap <= pick_gap();
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one row and wait for its transfer; valid stays up for a back-to-back row
  task automatic send_row(input logic [ROW_W-1:0] cells, input logic bottom);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cells;
    s_axis_tlast <= bottom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    rows_sent++;
  endtask

  task automatic stop_rows();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  // Register write with the block idle
  task automatic write_width(input logic [CFG_W-1:0] w);
    stop_rows();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return a & b;          // sparse
      1: return a | b;          // dense
      default: return a;
    endcase
  endfunction

  task automatic send_frame(input int rows);
    for (int i = 0; i < rows; i++) send_row(rand_row(), i == rows - 1);
  endtask

  // Known patterns at reset width: single row, edges, oscillators
  task automatic test_patterns();
    send_row('1, 1'b1);                        // single-row grid
    send_row('0, 1'b0);
    send_row('1, 1'b1);
    send_row('0, 1'b0);                        // blinker
    send_row(64'h0000_0000_0000_1C00, 1'b0);
    send_row('0, 1'b1);
    send_row(64'h8000_0000_0000_0003, 1'b0);   // live cells on both edges
    send_row(64'hC000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0003, 1'b1);
    send_row(64'hC000_0000_0000_0000, 1'b0);   // block against the top column
    send_row(64'hC000_0000_0000_0000, 1'b1);
  endtask

  // Width sweep including zero width and widths past the cell count
  task automatic test_widths();
    logic [CFG_W-1:0] widths[8];
    widths = '{7'd1, 7'd2, 7'd3, 7'd0, 7'd63, 7'd65, 7'd127, 7'd64};
    foreach (widths[i]) begin
      write_width(widths[i]);
      send_row(rand_row(), 1'b0);
      send_row('1, 1'b1);
    end
  endtask

  // Width change while a frame holds rows
  task automatic test_width_mid_frame();
    send_row(64'hFFFF_0000_FFFF_0F0F, 1'b0);
    send_row(64'h0F0F_FFFF_0000_FFFF, 1'b0);
    write_width(7'd10);
    send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    write_width(7'd40);
    send_row(64'h5555_5555_5555_5555, 1'b1);
    write_width(7'd64);
  endtask

  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(0, 5))
      0, 1: return 7'd64;
      2: return CFG_W'($urandom_range(1, 8));
      3: return CFG_W'($urandom_range(56, 70));
      default: return CFG_W'($urandom_range(0, 127));
    endcase
  endfunction

  // Random frames of random height, width changed every few dozen rows
  task automatic test_random_frames();
    int stop_at, next_write;
    stop_at = rows_sent + RANDOM_ROWS;
    next_write = rows_sent;
    while (rows_sent < stop_at) begin
      if (rows_sent >= next_write) begin
        write_width(pick_width());
        next_write = rows_sent + $urandom_range(20, 60);
      end
      if ($urandom_range(0, 9) == 0) send_frame(1);
      else send_frame($urandom_range(2, 12));
    end
  endtask

  // Receiver holds off while rows keep coming at full rate
  task automatic test_backpressure();
    write_width(7'd64);
    steady = 1'b1;
    hold_requests++;
    for (int i = 0; i < 5; i++) send_frame(8);
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_patterns();
    test_widths();
    test_width_mid_frame();
    test_backpressure();
    test_random_frames();
    stop_rows();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
